[design/snd_pkg.sv]
// Shared types, sizes and codes for the Sobel / suppression / threshold block.
// Used by every module under design/ except snd_ram; depends on nothing.
package snd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int PIX_W     = 8;
  localparam int MAG_W     = 11;

  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int POS_W  = (DIM_W > HDIM_W) ? DIM_W : HDIM_W;

  // ring of gray pixels: two rows behind and two rows ahead of a result
  localparam int GRAY_DEPTH = 4 * MAX_WIDTH + 8;
  localparam int ADDR_W     = $clog2(GRAY_DEPTH);
  localparam int PEND_W     = $clog2(2 * MAX_WIDTH + 4);

  // gradient arithmetic
  localparam int GRAD_W     = 12;
  localparam int ABS_W      = 10;
  localparam int OPND_W     = 11;
  localparam int ASQ_W      = 2 * ABS_W;
  localparam int SQ_W       = 2 * OPND_W;
  localparam int ROOT_W     = SQ_W / 2;
  localparam int SQRT_STEPS = SQ_W / 2;

  localparam int WIN_N     = 9;
  localparam int WIN_IDX_W = 4;

  localparam logic [1:0] STR_NONE   = 2'd0;
  localparam logic [1:0] STR_WEAK   = 2'd1;
  localparam logic [1:0] STR_STRONG = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_LOW_THRESHOLD,
    REG_HIGH_THRESHOLD
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_CENTER,
    PH_N1,
    PH_N2
  } phase_e;

  typedef enum logic [2:0] {
    ADDR_HOLD,
    ADDR_BASE_OFF,
    ADDR_ORIGIN,
    ADDR_STEP,
    ADDR_ROW
  } addr_op_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_A,
    MUL_B,
    MUL_S
  } mul_sel_e;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             filler;
  } pix_t;

  typedef struct packed {
    logic             thin_edge;
    logic [1:0]       strength;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    logic                 accept;
    addr_op_e             addr_op;
    logic                 cap_en;
    logic [WIN_IDX_W-1:0] cap_idx;
    logic                 grad;
    mul_sel_e             mul_sel;
    logic                 sqrt_init;
    logic                 sqrt_step;
    logic                 store_mag;
    phase_e               phase;
    logic                 load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic center_border;
    logic n1_border;
    logic n2_border;
    logic out_busy;
  } status_t;

endpackage

[design/sobel_nms_double_threshold.sv]
// A result is presented in the cycle after its work ends; a border pixel
// skips the gradient work, an interior pixel evaluates a magnitude for the
// center and for each non-border neighbor (up to two). No new request is taken
// until the current one is done; requests that release no result keep it idle.
// Work is paced by the single gray ring read port and the shared squarer and square root unit.
// Reset (rst_ni, async low) restores the register defaults and clears counters.
module sobel_nms_double_threshold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [snd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [snd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  snd_pkg::pix_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output snd_pkg::res_t                 out_data_o
);

  snd_pkg::cmd_t    cmd;
  snd_pkg::status_t st;

  snd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  snd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .st_o        (st)
  );

endmodule

[design/snd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module snd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/snd_isqrt.sv]
// Iterative floor square root, two radicand bits per step.
// Depends on snd_pkg for widths.
module snd_isqrt (
  input  logic                      clk_i,
  input  logic                      init_i,
  input  logic                      step_i,
  input  logic [snd_pkg::SQ_W-1:0]  value_i,
  output logic [snd_pkg::ROOT_W-1:0] root_o
);

  localparam int REM_W = snd_pkg::ROOT_W + 1;

  logic [snd_pkg::SQ_W-1:0]   x_q, x_d;
  logic [REM_W-1:0]           rem_q, rem_d;
  logic [snd_pkg::ROOT_W-1:0] root_q, root_d;
  logic [REM_W+1:0]           rem_sh, trial;

  // one restoring step: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_sh = {rem_q, x_q[snd_pkg::SQ_W-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (init_i) begin
      x_d    = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (step_i) begin
      x_d = {x_q[snd_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_q[snd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_q[snd_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;

endmodule

[design/snd_datapath.sv]
// Datapath: config registers, frame counters, gray ring, 3x3 window, Sobel,
// squaring, square root, suppression and output register. Uses snd_pkg,
// snd_ram and snd_isqrt.
module snd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [snd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [snd_pkg::CFG_W-1:0]     cfg_data_i,
  input  snd_pkg::pix_t                 in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output snd_pkg::res_t                 out_data_o,
  input  snd_pkg::cmd_t                 cmd_i,
  output snd_pkg::status_t              st_o
);

  localparam int ADDR_W  = snd_pkg::ADDR_W;
  localparam int AEXT_W  = ADDR_W + 1;
  localparam int DIM_W   = snd_pkg::DIM_W;
  localparam int HDIM_W  = snd_pkg::HDIM_W;
  localparam int POS_W   = snd_pkg::POS_W;
  localparam int COL_W   = snd_pkg::COL_W;
  localparam int ROW_W   = snd_pkg::ROW_W;
  localparam int PEND_W  = snd_pkg::PEND_W;
  localparam int CFG_W   = snd_pkg::CFG_W;
  localparam int WEXT_W  = (CFG_W > POS_W) ? CFG_W : POS_W;
  localparam int GRAD_W  = snd_pkg::GRAD_W;
  localparam int ABS_W   = snd_pkg::ABS_W;
  localparam int OPND_W  = snd_pkg::OPND_W;
  localparam int ASQ_W   = snd_pkg::ASQ_W;
  localparam int SQ_W    = snd_pkg::SQ_W;
  localparam int MAG_W   = snd_pkg::MAG_W;
  localparam int PIX_W   = snd_pkg::PIX_W;
  localparam int SUM_W   = PIX_W + 2;
  localparam int GPROD_W = 20;

  // gray = sum / 3 as a multiply by 683/2048, exact for sums up to 765
  localparam int GrayRecip = 683;
  localparam int GrayShift = 11;

  localparam logic [ADDR_W-1:0] DEPTH_A = ADDR_W'(snd_pkg::GRAY_DEPTH);

  localparam logic [1:0] STEP_0 = 2'b00;
  localparam logic [1:0] STEP_P = 2'b01;
  localparam logic [1:0] STEP_N = 2'b11;

  typedef enum logic [1:0] {
    DIR_H,
    DIR_V,
    DIR_DM,
    DIR_DA
  } dir_e;

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] x,
                                                 input logic [ADDR_W-1:0] y);
    logic [AEXT_W-1:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= AEXT_W'(snd_pkg::GRAY_DEPTH)) begin
      s = s - AEXT_W'(snd_pkg::GRAY_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  // {row step, column step} of a suppression neighbor
  function automatic logic [3:0] nbr_step(input dir_e d, input logic second);
    logic [3:0] s;
    unique case (d)
      DIR_H:   s = second ? {STEP_0, STEP_N} : {STEP_0, STEP_P};
      DIR_V:   s = second ? {STEP_N, STEP_0} : {STEP_P, STEP_0};
      DIR_DM:  s = second ? {STEP_P, STEP_P} : {STEP_N, STEP_N};
      DIR_DA:  s = second ? {STEP_P, STEP_N} : {STEP_N, STEP_P};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p,
                                                input logic [1:0] d);
    logic [POS_W-1:0] q;
    if (d == STEP_P) begin
      q = p + POS_W'(1);
    end else if (d == STEP_N) begin
      q = p - POS_W'(1);
    end else begin
      q = p;
    end
    return q;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] fw_q, fh_q, lo_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= CFG_W'(640);
      fh_q <= CFG_W'(480);
      lo_q <= CFG_W'(100);
      hi_q <= CFG_W'(175);
    end else if (cfg_we_i) begin
      unique case (snd_pkg::cfg_reg_e'(cfg_index_i))
        snd_pkg::REG_FRAME_WIDTH:    fw_q <= cfg_data_i;
        snd_pkg::REG_FRAME_HEIGHT:   fh_q <= cfg_data_i;
        snd_pkg::REG_LOW_THRESHOLD:  lo_q <= cfg_data_i;
        snd_pkg::REG_HIGH_THRESHOLD: hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp frame size into 3..max
  logic [WEXT_W-1:0] fw_ext, fh_ext;
  logic [POS_W-1:0]  w_p, h_p;
  logic [DIM_W-1:0]  w;
  logic [HDIM_W-1:0] h;
  logic [ADDR_W-1:0] w_a;

  assign fw_ext = WEXT_W'(fw_q);
  assign fh_ext = WEXT_W'(fh_q);
  assign w = (fw_ext < WEXT_W'(3)) ? DIM_W'(3) :
             (fw_ext > WEXT_W'(snd_pkg::MAX_WIDTH)) ? DIM_W'(snd_pkg::MAX_WIDTH) :
             DIM_W'(fw_ext);
  assign h = (fh_ext < WEXT_W'(3)) ? HDIM_W'(3) :
             (fh_ext > WEXT_W'(snd_pkg::MAX_HEIGHT)) ? HDIM_W'(snd_pkg::MAX_HEIGHT) :
             HDIM_W'(fh_ext);
  assign w_p = POS_W'(w);
  assign h_p = POS_W'(h);
  assign w_a = ADDR_W'(w);

  // gray conversion
  logic [SUM_W-1:0]   rgb_sum;
  logic [GPROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]   gray;

  assign rgb_sum   = SUM_W'(in_data_i.red) + SUM_W'(in_data_i.green) +
                     SUM_W'(in_data_i.blue);
  assign gray_prod = GPROD_W'(rgb_sum) * GPROD_W'(GrayRecip);
  assign gray      = gray_prod[GrayShift +: PIX_W];

  // input and output frame positions, ring pointer, pending count
  logic [COL_W-1:0]  col_q, out_col_q, c_q;
  logic [ROW_W-1:0]  row_q, out_row_q, r_q;
  logic [ADDR_W-1:0] wa_q, base_q;
  logic [PEND_W-1:0] pend_q;
  logic              fend_q;

  logic              pixel, emit;
  logic [DIM_W-1:0]  col_p1, ocol_p1;
  logic [HDIM_W-1:0] row_p1, orow_p1;
  logic [COL_W-1:0]  col_adv, ocol_adv;
  logic [ROW_W-1:0]  row_adv, orow_adv;
  logic [PEND_W-1:0] pend_new, two_w2;
  logic [ADDR_W-1:0] wa_inc, wa_post, base_new;
  logic              fend_new;

  always_comb begin
    pixel = !in_data_i.filler;

    col_p1  = DIM_W'(col_q) + DIM_W'(1);
    row_p1  = HDIM_W'(row_q) + HDIM_W'(1);
    col_adv = (col_p1 >= w) ? '0 : COL_W'(col_p1);
    row_adv = (col_p1 < w) ? row_q : (row_p1 >= h) ? '0 : ROW_W'(row_p1);

    ocol_p1  = DIM_W'(out_col_q) + DIM_W'(1);
    orow_p1  = HDIM_W'(out_row_q) + HDIM_W'(1);
    ocol_adv = (ocol_p1 >= w) ? '0 : COL_W'(ocol_p1);
    orow_adv = (ocol_p1 < w) ? out_row_q : (orow_p1 >= h) ? '0 : ROW_W'(orow_p1);

    pend_new = pend_q + PEND_W'(pixel);
    two_w2   = PEND_W'({w, 1'b0}) + PEND_W'(2);
    if (pixel) begin
      emit = pend_new > two_w2;
    end else begin
      emit = (col_q == '0) && (row_q == '0) && (pend_q != '0);
    end

    wa_inc   = wrap_add(wa_q, ADDR_W'(1));
    wa_post  = pixel ? wa_inc : wa_q;
    base_new = wrap_add(wa_post, DEPTH_A - ADDR_W'(pend_new));
    fend_new = (HDIM_W'(out_row_q) == h - HDIM_W'(1)) &&
               (DIM_W'(out_col_q) == w - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      wa_q      <= '0;
      pend_q    <= '0;
    end else if (cmd_i.accept) begin
      if (pixel) begin
        wa_q  <= wa_inc;
        col_q <= col_adv;
        row_q <= row_adv;
      end
      if (emit) begin
        pend_q    <= pend_new - PEND_W'(1);
        out_col_q <= ocol_adv;
        out_row_q <= orow_adv;
      end else begin
        pend_q <= pend_new;
      end
    end
  end

  // latch the position of the result being worked on, then its magnitudes and direction
  logic [MAG_W-1:0] magc_q, n1_q, n2_q;
  logic [snd_pkg::ROOT_W-1:0] root;
  dir_e             dir_q, dir_new;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && emit) begin
      base_q <= base_new;
      r_q    <= out_row_q;
      c_q    <= out_col_q;
      fend_q <= fend_new;
      n1_q   <= '0;
      n2_q   <= '0;
    end else if (cmd_i.store_mag) begin
      unique case (cmd_i.phase)
        snd_pkg::PH_CENTER: begin
          magc_q <= MAG_W'(root);
          dir_q  <= dir_new;
        end
        snd_pkg::PH_N1: n1_q <= MAG_W'(root);
        snd_pkg::PH_N2: n2_q <= MAG_W'(root);
        default: ;
      endcase
    end
  end

  // border tests for the center and both neighbors
  logic [POS_W-1:0] r_p, c_p, n1r, n1c, n2r, n2c;
  logic [3:0]       s1, s2, scur;
  logic             cb, n1b, n2b;

  always_comb begin
    r_p = POS_W'(r_q);
    c_p = POS_W'(c_q);
    s1  = nbr_step(dir_q, 1'b0);
    s2  = nbr_step(dir_q, 1'b1);
    n1r = pos_step(r_p, s1[3:2]);
    n1c = pos_step(c_p, s1[1:0]);
    n2r = pos_step(r_p, s2[3:2]);
    n2c = pos_step(c_p, s2[1:0]);
    cb  = (r_p == '0) || (c_p == '0) || (r_p >= h_p - POS_W'(1)) ||
          (c_p >= w_p - POS_W'(1));
    n1b = (n1r == '0) || (n1c == '0) || (n1r >= h_p - POS_W'(1)) ||
          (n1c >= w_p - POS_W'(1));
    n2b = (n2r == '0) || (n2c == '0) || (n2r >= h_p - POS_W'(1)) ||
          (n2c >= w_p - POS_W'(1));
    unique case (cmd_i.phase)
      snd_pkg::PH_N1: scur = s1;
      snd_pkg::PH_N2: scur = s2;
      default:        scur = {STEP_0, STEP_0};
    endcase
  end

  // window address walk over the ring
  logic [ADDR_W-1:0] addr_q, addr_d, row_part, col_part, off;

  always_comb begin
    row_part = (scur[3:2] == STEP_P) ? w_a :
               (scur[3:2] == STEP_N) ? DEPTH_A - w_a : '0;
    col_part = (scur[1:0] == STEP_P) ? ADDR_W'(1) :
               (scur[1:0] == STEP_N) ? DEPTH_A - ADDR_W'(1) : '0;
    off      = wrap_add(row_part, col_part);
    unique case (cmd_i.addr_op)
      snd_pkg::ADDR_BASE_OFF: addr_d = wrap_add(base_q, off);
      snd_pkg::ADDR_ORIGIN:   addr_d = wrap_add(addr_q, DEPTH_A - w_a - ADDR_W'(1));
      snd_pkg::ADDR_STEP:     addr_d = wrap_add(addr_q, ADDR_W'(1));
      snd_pkg::ADDR_ROW:      addr_d = wrap_add(addr_q, w_a - ADDR_W'(2));
      default:                addr_d = addr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  logic [PIX_W-1:0] rdata;

  snd_ram #(
    .Width (PIX_W),
    .Depth (snd_pkg::GRAY_DEPTH)
  ) u_gray_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && pixel),
    .waddr_i (wa_q),
    .wdata_i (gray),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  // 3x3 window, row-major from upper left
  logic [PIX_W-1:0] win_q [snd_pkg::WIN_N];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      win_q[cmd_i.cap_idx] <= rdata;
    end
  end

  // Sobel sums
  logic signed [GRAD_W-1:0] ws [snd_pkg::WIN_N];
  logic signed [GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;

  always_comb begin
    for (int i = 0; i < snd_pkg::WIN_N; i++) begin
      ws[i] = $signed(GRAD_W'(win_q[i]));
    end
    gx_d = ws[0] - ws[2] + (ws[3] <<< 1) - (ws[5] <<< 1) + ws[6] - ws[8];
    gy_d = ws[0] + (ws[1] <<< 1) + ws[2] - ws[6] - (ws[7] <<< 1) - ws[8];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  // shared squarer
  logic [GRAD_W-1:0] gx_abs, gy_abs;
  logic [ABS_W-1:0]  a, b;
  logic [OPND_W-1:0] mul_op;
  logic [SQ_W-1:0]   prod, ssq_q;
  logic [ASQ_W-1:0]  asq_q, bsq_q;

  always_comb begin
    gx_abs = gx_q[GRAD_W-1] ? GRAD_W'(-gx_q) : GRAD_W'(gx_q);
    gy_abs = gy_q[GRAD_W-1] ? GRAD_W'(-gy_q) : GRAD_W'(gy_q);
    a      = gx_abs[ABS_W-1:0];
    b      = gy_abs[ABS_W-1:0];
    unique case (cmd_i.mul_sel)
      snd_pkg::MUL_A: mul_op = OPND_W'(a);
      snd_pkg::MUL_B: mul_op = OPND_W'(b);
      snd_pkg::MUL_S: mul_op = OPND_W'(a) + OPND_W'(b);
      default:        mul_op = '0;
    endcase
    prod = SQ_W'(mul_op) * SQ_W'(mul_op);
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.mul_sel)
      snd_pkg::MUL_A: asq_q <= ASQ_W'(prod);
      snd_pkg::MUL_B: bsq_q <= ASQ_W'(prod);
      snd_pkg::MUL_S: ssq_q <= prod;
      default: ;
    endcase
  end

  snd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .init_i  (cmd_i.sqrt_init),
    .step_i  (cmd_i.sqrt_step),
    .value_i (SQ_W'(asq_q) + SQ_W'(bsq_q)),
    .root_o  (root)
  );

  // round the direction to 45 degrees
  logic gx_pos, gy_pos;

  always_comb begin
    gx_pos = !gx_q[GRAD_W-1] && (gx_q != '0);
    gy_pos = !gy_q[GRAD_W-1] && (gy_q != '0);
    if ((b == '0) || (ssq_q < SQ_W'({asq_q, 1'b0}))) begin
      dir_new = DIR_H;
    end else if (ssq_q < SQ_W'({bsq_q, 1'b0})) begin
      dir_new = DIR_V;
    end else if (gx_pos == gy_pos) begin
      dir_new = DIR_DM;
    end else begin
      dir_new = DIR_DA;
    end
  end

  // result and output register
  snd_pkg::res_t res, out_q;
  logic          out_valid_q;

  always_comb begin
    res.frame_end = fend_q;
    if (cb) begin
      res.thin_edge = 1'b0;
      res.strength  = snd_pkg::STR_NONE;
      res.magnitude = '0;
    end else begin
      res.thin_edge = (magc_q >= n1_q) && (magc_q >= n2_q);
      res.magnitude = magc_q;
      priority if (magc_q >= hi_q) begin
        res.strength = snd_pkg::STR_STRONG;
      end else if (magc_q >= lo_q) begin
        res.strength = snd_pkg::STR_WEAK;
      end else begin
        res.strength = snd_pkg::STR_NONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign st_o.emit          = emit;
  assign st_o.center_border = cb;
  assign st_o.n1_border     = n1b;
  assign st_o.n2_border     = n2b;
  assign st_o.out_busy      = out_valid_q && !out_ready_i;

  // ring write pointer stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) wa_q < DEPTH_A)
    else $error("gray ring write pointer out of range");

  // a loaded result shows valid next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  // never overwrite a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !out_ready_i))
    else $error("held result overwritten");

endmodule

[design/snd_ctrl.sv]
// Sequencer: accepts requests and steps the datapath through the window
// reads, gradient, square root and suppression for each result. Uses snd_pkg.
module snd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  snd_pkg::status_t st_i,
  output snd_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LOAD,
    S_ORIGIN,
    S_READ,
    S_GRAD,
    S_MULA,
    S_MULB,
    S_MULS,
    S_SQRT,
    S_STORE,
    S_NEXT,
    S_OUT
  } state_e;

  localparam logic [3:0] LastRead = 4'(snd_pkg::WIN_N);
  localparam logic [3:0] LastSqrt = 4'(snd_pkg::SQRT_STEPS - 1);

  state_e            state_q, state_d;
  snd_pkg::phase_e   phase_q, phase_d;
  logic [3:0]        cnt_q, cnt_d;

  always_comb begin
    state_d          = state_q;
    phase_d          = phase_q;
    cnt_d            = cnt_q;
    cmd_o            = '0;
    cmd_o.addr_op    = snd_pkg::ADDR_HOLD;
    cmd_o.mul_sel    = snd_pkg::MUL_NONE;
    cmd_o.phase      = phase_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      // take a request; start work if it releases a result
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (st_i.emit) begin
            state_d = S_CHECK;
          end
        end
      end
      // border pixels skip the gradient work
      S_CHECK: begin
        if (st_i.center_border) begin
          state_d = S_OUT;
        end else begin
          phase_d = snd_pkg::PH_CENTER;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.addr_op = snd_pkg::ADDR_BASE_OFF;
        state_d       = S_ORIGIN;
      end
      S_ORIGIN: begin
        cmd_o.addr_op = snd_pkg::ADDR_ORIGIN;
        cnt_d         = '0;
        state_d       = S_READ;
      end
      // issue nine reads, capture each from the registered read data in the cycle after
      S_READ: begin
        if (cnt_q < LastRead) begin
          cmd_o.addr_op = ((cnt_q == 4'd2) || (cnt_q == 4'd5)) ? snd_pkg::ADDR_ROW
                                                               : snd_pkg::ADDR_STEP;
        end
        if (cnt_q != '0) begin
          cmd_o.cap_en  = 1'b1;
          cmd_o.cap_idx = cnt_q - 4'd1;
        end
        if (cnt_q == LastRead) begin
          state_d = S_GRAD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_sel = snd_pkg::MUL_A;
        state_d       = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_sel = snd_pkg::MUL_B;
        state_d       = S_MULS;
      end
      S_MULS: begin
        cmd_o.mul_sel   = snd_pkg::MUL_S;
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (cnt_q == LastSqrt) begin
          state_d = S_STORE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_STORE: begin
        cmd_o.store_mag = 1'b1;
        state_d         = S_NEXT;
      end
      // pick the next neighbor that needs a magnitude
      S_NEXT: begin
        unique case (phase_q)
          snd_pkg::PH_CENTER: begin
            if (!st_i.n1_border) begin
              phase_d = snd_pkg::PH_N1;
              state_d = S_LOAD;
            end else if (!st_i.n2_border) begin
              phase_d = snd_pkg::PH_N2;
              state_d = S_LOAD;
            end else begin
              state_d = S_OUT;
            end
          end
          snd_pkg::PH_N1: begin
            if (!st_i.n2_border) begin
              phase_d = snd_pkg::PH_N2;
              state_d = S_LOAD;
            end else begin
              state_d = S_OUT;
            end
          end
          default: state_d = S_OUT;
        endcase
      end
      // hold until the output register is free
      S_OUT: begin
        if (!st_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= snd_pkg::PH_CENTER;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (cnt_q <= LastRead))
    else $error("window read count overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SQRT) |-> (cnt_q <= LastSqrt))
    else $error("square root step count overran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && phase_q == snd_pkg::PH_N1) |-> !st_i.n1_border)
    else $error("gradient started for a border neighbor");

endmodule

[bench/testbench.sv]
// Self-checking bench for sobel_nms_double_threshold: predicts gradient magnitude,
// suppression and threshold class per pixel and compares each result in order.
// Depends on design/snd_pkg.sv and the block's RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 4 * snd_pkg::MAX_WIDTH + 8;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [snd_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [snd_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  snd_pkg::pix_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  snd_pkg::res_t out_data_o;

  sobel_nms_double_threshold DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // shadow of the block: registers, gray ring and raster positions
  int unsigned width_reg = 640, height_reg = 480, low_reg = 100, high_reg = 175;
  logic [7:0] gray_ring [RING];
  int unsigned wr_ptr = 0, in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  int unsigned backlog = 0;

  snd_pkg::pix_t pixel_q[$];
  snd_pkg::res_t result_q[$];
  int errors = 0;

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v < 3) return 3;
    if (v > snd_pkg::MAX_WIDTH) return snd_pkg::MAX_WIDTH;
    return v;
  endfunction

  task automatic next_pos(inout int unsigned col, inout int unsigned row,
                          input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  function automatic int ring_at(int base, int off);
    return int'(gray_ring[(base + RING + off) % RING]);
  endfunction

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned x, res, b;
    x = v;
    res = 0;
    b = 1 << 30;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit on_border(int r, int c, int w, int h);
    return r <= 0 || c <= 0 || r >= h - 1 || c >= w - 1;
  endfunction

  // Sobel magnitude of the pixel at (r,c) stored at ring address base
  function automatic int unsigned sobel_mag(int base, int r, int c, int w, int h,
                                            output int gx, output int gy);
    gx = 0;
    gy = 0;
    if (on_border(r, c, w, h)) return 0;
    gx = ring_at(base, -w - 1) - ring_at(base, -w + 1) + 2 * ring_at(base, -1)
       - 2 * ring_at(base, 1) + ring_at(base, w - 1) - ring_at(base, w + 1);
    gy = ring_at(base, -w - 1) + 2 * ring_at(base, -w) + ring_at(base, -w + 1)
       - ring_at(base, w - 1) - 2 * ring_at(base, w) - ring_at(base, w + 1);
    return floor_root(gx * gx + gy * gy);
  endfunction

  function automatic int unsigned mag_beside(int base, int r, int c, int dr, int dc,
                                             int w, int h);
    int gx, gy;
    return sobel_mag((base + RING + dr * w + dc) % RING, r + dr, c + dc, w, h, gx, gy);
  endfunction

  // absorb one accepted request and queue the result it releases, if any
  task automatic absorb(snd_pkg::pix_t p);
    int unsigned w, h, m, n1, n2, a, b, s;
    int base, r, c, gx, gy, d1r, d1c;
    bit emit;
    snd_pkg::res_t e;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    emit = 0;
    if (!p.filler) begin
      gray_ring[wr_ptr] = 8'((int'(p.red) + int'(p.green) + int'(p.blue)) / 3);
      wr_ptr = (wr_ptr + 1) % RING;
      next_pos(in_col, in_row, w, h);
      backlog++;
      emit = backlog > 2 * w + 2;
    end else begin
      emit = in_col == 0 && in_row == 0 && backlog > 0;
    end
    if (emit) begin
      base = (wr_ptr + RING - backlog) % RING;
      backlog--;
      r = out_row;
      c = out_col;
      e = '0;
      e.frame_end = (out_row == h - 1) && (out_col == w - 1);
      next_pos(out_col, out_row, w, h);
      m = sobel_mag(base, r, c, w, h, gx, gy);
      e.magnitude = snd_pkg::MAG_W'(m);
      if (!on_border(r, c, w, h)) begin
        a = gx < 0 ? -gx : gx;
        b = gy < 0 ? -gy : gy;
        s = (a + b) * (a + b);
        if (b == 0 || s < 2 * a * a) begin
          d1r = 0; d1c = 1;
        end else if (s < 2 * b * b) begin
          d1r = 1; d1c = 0;
        end else if ((gx > 0) == (gy > 0)) begin
          d1r = -1; d1c = -1;
        end else begin
          d1r = -1; d1c = 1;
        end
        n1 = mag_beside(base, r, c, d1r, d1c, w, h);
        n2 = mag_beside(base, r, c, -d1r, -d1c, w, h);
        e.thin_edge = m >= n1 && m >= n2;
        if (m >= high_reg) e.strength = snd_pkg::STR_STRONG;
        else if (m >= low_reg) e.strength = snd_pkg::STR_WEAK;
        else e.strength = snd_pkg::STR_NONE;
      end
      result_q.push_back(e);
    end
  endtask

  // sender: bursts of random length, separated at times by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) absorb(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_data_i <= pixel_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern rotates among always ready, random and periodic
  int unsigned rx_cycle = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle / 400) % 3)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= $urandom_range(0, 3) != 0;
      end
      default: begin
        out_ready_i <= (rx_cycle % 29) >= 15;
      end
    endcase
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    snd_pkg::res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result %p", out_data_o);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_data_o.thin_edge !== e.thin_edge) begin
          $error("thin_edge expected %0d actual %0d", e.thin_edge, out_data_o.thin_edge);
          errors++;
        end
        if (out_data_o.strength !== e.strength) begin
          $error("strength expected %0d actual %0d", e.strength, out_data_o.strength);
          errors++;
        end
        if (out_data_o.magnitude !== e.magnitude) begin
          $error("magnitude expected %0d actual %0d", e.magnitude, out_data_o.magnitude);
          errors++;
        end
        if (out_data_o.frame_end !== e.frame_end) begin
          $error("frame_end expected %0d actual %0d", e.frame_end, out_data_o.frame_end);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(snd_pkg::cfg_reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= snd_pkg::CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      snd_pkg::REG_FRAME_WIDTH:   width_reg = val;
      snd_pkg::REG_FRAME_HEIGHT:  height_reg = val;
      snd_pkg::REG_LOW_THRESHOLD: low_reg = val;
      default:                    high_reg = val;
    endcase
  endtask

  task automatic setup(int unsigned w, int unsigned h, int unsigned lo, int unsigned hi);
    write_reg(snd_pkg::REG_FRAME_WIDTH, w);
    write_reg(snd_pkg::REG_FRAME_HEIGHT, h);
    write_reg(snd_pkg::REG_LOW_THRESHOLD, lo);
    write_reg(snd_pkg::REG_HIGH_THRESHOLD, hi);
  endtask

  // hold until all requests are taken and all results are back, then let the block settle
  task automatic wait_idle();
    do @(posedge clk_i); while (pixel_q.size() > 0 || in_valid_i || result_q.size() > 0);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic snd_pkg::pix_t make_pixel(int style);
    snd_pkg::pix_t p;
    p.filler = 1'b0;
    if (style == 0) begin
      p.red = 8'($urandom_range(0, 255));
      p.green = 8'($urandom_range(0, 255));
      p.blue = 8'($urandom_range(0, 255));
    end else begin
      p.red = $urandom_range(0, 1) ? 8'hff : 8'h00;
      p.green = p.red;
      p.blue = $urandom_range(0, 3) == 0 ? ~p.red : p.red;
    end
    return p;
  endfunction

  // queue one frame of pixels, with stray fillers mixed in; drain adds flush fillers
  task automatic add_frame(int unsigned npix, int unsigned w, int style, bit drain);
    snd_pkg::pix_t f;
    f = '0;
    f.filler = 1'b1;
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        f.red = 8'($urandom());
        pixel_q.push_back(f);
      end
      pixel_q.push_back(make_pixel(style));
    end
    if (drain) begin
      for (int unsigned i = 0; i < 2 * w + 5; i++) pixel_q.push_back(f);
    end
  endtask

  initial begin
    int unsigned sent, w, h, frames;
    snd_pkg::pix_t p;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // smallest frame with channel extremes; stray filler before any pixel
    setup(3, 3, 0, 0);
    p = '0;
    p.filler = 1'b1;
    pixel_q.push_back(p);
    p = '0;
    pixel_q.push_back(p);
    p.red = 8'hff; p.green = 8'hff; p.blue = 8'hff;
    pixel_q.push_back(p);
    add_frame(7, 3, 1, 1);
    wait_idle();

    // thresholds at the top, then high below low
    setup(5, 4, 2047, 2047);
    add_frame(20, 5, 1, 1);
    wait_idle();
    setup(6, 5, 500, 50);
    add_frame(30, 6, 1, 1);
    wait_idle();

    // out-of-range sizes clamp low
    setup(0, 2, 100, 175);
    add_frame(9, 3, 0, 1);
    wait_idle();

    // random: groups of back-to-back frames sharing one setting
    sent = 0;
    while (sent < 960) begin
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      setup(w, h, $urandom_range(0, 600), $urandom_range(0, 1443));
      frames = $urandom_range(1, 3);
      for (int i = 0; i < frames; i++) begin
        add_frame(w * h, w, $urandom_range(0, 1), i == frames - 1);
        sent += w * h;
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("sobel_nms_double_threshold test passed");
    end else begin
      $display("sobel_nms_double_threshold test failed");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("sobel_nms_double_threshold test failed");
    $finish;
  end

endmodule

[filelist.f]
design/snd_pkg.sv
design/snd_ram.sv
design/snd_isqrt.sv
design/snd_datapath.sv
design/snd_ctrl.sv
design/sobel_nms_double_threshold.sv
bench/testbench.sv
